// ===== rtl/core/cpat_pkg.sv =====
// shared codes, state encoding and controller/datapath interface types
`default_nettype none

package cpat_pkg;

    // operation codes carried in s_tuser
    localparam logic [3:0] FN_SET_ACTIVE  = 4'd0;
    localparam logic [3:0] FN_START       = 4'd1;
    localparam logic [3:0] FN_STOP        = 4'd2;
    localparam logic [3:0] FN_SEND        = 4'd3;
    localparam logic [3:0] FN_SEND_ZERO   = 4'd4;
    localparam logic [3:0] FN_RECV        = 4'd5;
    localparam logic [3:0] FN_RECV_ZERO   = 4'd6;
    localparam logic [3:0] FN_SAMPLE      = 4'd7;
    localparam logic [3:0] FN_SAMPLE_ZERO = 4'd8;

    // record kinds carried in m_tuser
    localparam logic [1:0] KIND_PATH      = 2'd0;
    localparam logic [1:0] KIND_PATH_ZERO = 2'd1;
    localparam logic [1:0] KIND_SAMPLE    = 2'd2;
    localparam logic [1:0] KIND_FULL      = 2'd3;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOOK  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_DELTA = 6'b001000,
        ST_SUM   = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    // one strobe per datapath step
    typedef struct packed {
        logic capture;
        logic lookup;
        logic read;
        logic delta;
        logic sum;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/critical_path_accumulator_table_unit.sv =====
// top level of the critical path accumulator table
// An item occupies the block until finish: the controller steps capture, key match,
// accumulator memory read, time delta, saturating sum and finish, one per cycle while finish is
// not held, and takes the next item only after finish. The table entry is written back and the
// result register loaded in the finish step. Finish waits only while a previous result
// still sits untaken in the output register, so with m_tready held high finish never waits.
// The table holds TABLE_ENTRIES ids; keys
// and valid bits are flip-flops matched in parallel, the totals, stamps and running flags
// live in single-port memories addressed by the matched or free slot. Valid bits clear at reset,
// no clearing pass is needed. Send and a sample of a present id give one record, a missing id on
// a full table gives a table full record for every op but a sample, everything else gives none.
`default_nettype none

module critical_path_accumulator_table_unit #(
    parameter int TABLE_ENTRIES = 16,
    parameter int TIME_BITS     = 48,
    parameter int ID_BITS       = 16
) (
    input  logic aclk,
    input  logic aresetn,

    // input channel
    input  logic s_tvalid,
    output logic s_tready,
    // id, now, remote_length, remote_share, zero pad
    input  logic [((ID_BITS + 3 * TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // func
    input  logic [3:0] s_tuser,

    // result channel
    output logic m_tvalid,
    input  logic m_tready,
    // out_id, length, share, zero pad
    output logic [((ID_BITS + 2 * TIME_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // kind
    output logic [1:0] m_tuser
);
    import cpat_pkg::*;

    localparam int M_DATA_W = ((ID_BITS + 2 * TIME_BITS + 7) / 8) * 8;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    logic [ID_BITS-1:0]   res_id;
    logic [TIME_BITS-1:0] res_length, res_share;

    // field offsets inside s_tdata
    logic [ID_BITS-1:0]   in_id;
    logic [TIME_BITS-1:0] in_now, in_rlen, in_rsh;

    assign in_id   = s_tdata[ID_BITS-1:0];
    assign in_now  = s_tdata[ID_BITS + TIME_BITS - 1:ID_BITS];
    assign in_rlen = s_tdata[ID_BITS + 2 * TIME_BITS - 1:ID_BITS + TIME_BITS];
    assign in_rsh  = s_tdata[ID_BITS + 3 * TIME_BITS - 1:ID_BITS + 2 * TIME_BITS];

    cpat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (dp_cmd),
        .status   (dp_status)
    );

    cpat_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TIME_BITS     (TIME_BITS),
        .ID_BITS       (ID_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (dp_cmd),
        .status           (dp_status),
        .in_func          (s_tuser),
        .in_id            (in_id),
        .in_now           (in_now),
        .in_remote_length (in_rlen),
        .in_remote_share  (in_rsh),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_kind         (m_tuser),
        .out_id           (res_id),
        .out_length       (res_length),
        .out_share        (res_share)
    );

    // pack result fields, zero filled up to whole bytes
    assign m_tdata = M_DATA_W'({res_share, res_length, res_id});

`ifndef SYNTHESIS
    a_single_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(dp_cmd))
        else $error("controller issued more than one datapath step");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while an item is in work");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_status.out_busy |-> !dp_cmd.finish)
        else $error("finish step while result still waits for its transfer");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(dp_cmd.finish))
        else $error("result appeared without a finish step");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/cpat_ctrl.sv =====
// sequencing state machine for the accumulator table
`default_nettype none

module cpat_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output cpat_pkg::dp_cmd_t    cmd,
    input  cpat_pkg::dp_status_t status
);
    import cpat_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK: begin
                cmd.lookup = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_DELTA;
            end
            ST_DELTA: begin
                cmd.delta  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // hold while the output register still waits for its transfer
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/cpat_dp.sv =====
// key store, accumulator memories, update arithmetic and output register
`default_nettype none

module cpat_dp #(
    parameter int TABLE_ENTRIES = 16,
    parameter int TIME_BITS     = 48,
    parameter int ID_BITS       = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cpat_pkg::dp_cmd_t      cmd,
    output cpat_pkg::dp_status_t   status,
    input  logic [3:0]             in_func,
    input  logic [ID_BITS-1:0]     in_id,
    input  logic [TIME_BITS-1:0]   in_now,
    input  logic [TIME_BITS-1:0]   in_remote_length,
    input  logic [TIME_BITS-1:0]   in_remote_share,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             out_kind,
    output logic [ID_BITS-1:0]     out_id,
    output logic [TIME_BITS-1:0]   out_length,
    output logic [TIME_BITS-1:0]   out_share
);
    import cpat_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [TIME_BITS-1:0] T_MAX = '1;

    // captured item
    logic [3:0]           func_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [TIME_BITS-1:0] now_reg, rlen_reg, rsh_reg;

    // associative part of the table
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [ID_BITS-1:0]       key_reg [TABLE_ENTRIES];

    // accumulator memories
    logic                 run_mem [TABLE_ENTRIES];
    logic [TIME_BITS-1:0] pt_mem  [TABLE_ENTRIES];
    logic [TIME_BITS-1:0] ps_mem  [TABLE_ENTRIES];
    logic [TIME_BITS-1:0] ot_mem  [TABLE_ENTRIES];
    logic [TIME_BITS-1:0] os_mem  [TABLE_ENTRIES];

    logic                 rd_run_reg;
    logic [TIME_BITS-1:0] rd_pt_reg, rd_ps_reg, rd_ot_reg, rd_os_reg;

    // lookup results
    logic             hit_reg, free_reg;
    logic [IDX_W-1:0] slot_reg;
    logic             hit_c, free_c;
    logic [IDX_W-1:0] hit_idx_c, free_idx_c;

    // delta stage
    logic                 run_reg;
    logic [TIME_BITS-1:0] pt_reg, ps_reg, ot_reg, os_reg, dp_reg, do_reg;
    logic                 e_run;
    logic [TIME_BITS-1:0] e_pt, e_ps, e_ot, e_os;

    // sum stage
    logic                 nrun_reg, nrun_c;
    logic [TIME_BITS-1:0] npt_reg, nps_reg, not_reg, nos_reg;
    logic [TIME_BITS-1:0] npt_c, nps_c, not_c, nos_c;
    logic [TIME_BITS:0]   pt_sum, ot_sum;
    logic [TIME_BITS-1:0] pt_upd, ot_upd;

    // finish stage
    logic                 op_update, op_sample, op_send, wr_en, emit;
    logic                 take_c;
    logic [TIME_BITS:0]   lhs_sum, rhs_sum;
    logic [TIME_BITS-1:0] wr_pt, wr_ot, zero_diff;
    logic [1:0]           kind_c;
    logic [TIME_BITS-1:0] len_c, sh_c;

    logic                 out_valid_reg;
    logic [1:0]           out_kind_reg;
    logic [ID_BITS-1:0]   out_id_reg;
    logic [TIME_BITS-1:0] out_len_reg, out_sh_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= in_func;
            id_reg   <= in_id;
            now_reg  <= in_now;
            rlen_reg <= in_remote_length;
            rsh_reg  <= in_remote_share;
        end
    end

    // match and lowest free slot
    always_comb begin
        hit_c      = 1'b0;
        free_c     = 1'b0;
        hit_idx_c  = '0;
        free_idx_c = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (valid_reg[i] && key_reg[i] == id_reg) begin
                hit_c     = 1'b1;
                hit_idx_c = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                free_c     = 1'b1;
                free_idx_c = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            hit_reg  <= hit_c;
            free_reg <= free_c;
            slot_reg <= hit_c ? hit_idx_c : free_idx_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rd_run_reg <= run_mem[slot_reg];
            rd_pt_reg  <= pt_mem[slot_reg];
            rd_ps_reg  <= ps_mem[slot_reg];
            rd_ot_reg  <= ot_mem[slot_reg];
            rd_os_reg  <= os_mem[slot_reg];
        end
    end

    // a freshly allocated entry looks like zero totals stamped at now
    always_comb begin
        e_run = hit_reg ? rd_run_reg : 1'b0;
        e_pt  = hit_reg ? rd_pt_reg  : '0;
        e_ps  = hit_reg ? rd_ps_reg  : now_reg;
        e_ot  = hit_reg ? rd_ot_reg  : '0;
        e_os  = hit_reg ? rd_os_reg  : now_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.delta) begin
            run_reg <= e_run;
            pt_reg  <= e_pt;
            ps_reg  <= e_ps;
            ot_reg  <= e_ot;
            os_reg  <= e_os;
            dp_reg  <= (now_reg >= e_ps) ? now_reg - e_ps : '0;
            do_reg  <= (now_reg >= e_os) ? now_reg - e_os : '0;
        end
    end

    always_comb begin
        pt_sum = {1'b0, pt_reg} + {1'b0, dp_reg};
        ot_sum = {1'b0, ot_reg} + {1'b0, do_reg};
        pt_upd = pt_sum[TIME_BITS] ? T_MAX : pt_sum[TIME_BITS-1:0];
        ot_upd = ot_sum[TIME_BITS] ? T_MAX : ot_sum[TIME_BITS-1:0];

        nrun_c = run_reg;
        npt_c  = pt_reg;
        nps_c  = ps_reg;
        not_c  = ot_reg;
        nos_c  = os_reg;
        unique case (func_reg) inside
            FN_SET_ACTIVE: begin
                nrun_c = 1'b1;
            end
            FN_START: begin
                nrun_c = 1'b1;
                npt_c  = pt_upd;
                nps_c  = now_reg;
                nos_c  = now_reg;
            end
            FN_STOP: begin
                nrun_c = 1'b0;
                npt_c  = pt_upd;
                nps_c  = now_reg;
                not_c  = ot_upd;
                nos_c  = now_reg;
            end
            FN_SEND, FN_SEND_ZERO, FN_RECV, FN_RECV_ZERO: begin
                npt_c = pt_upd;
                nps_c = now_reg;
                if (run_reg) begin
                    not_c = ot_upd;
                    nos_c = now_reg;
                end
            end
            FN_SAMPLE, FN_SAMPLE_ZERO: begin
                npt_c = pt_upd;
                if (run_reg) begin
                    not_c = ot_upd;
                end
            end
            default: begin
                nrun_c = run_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            nrun_reg <= nrun_c;
            npt_reg  <= npt_c;
            nps_reg  <= nps_c;
            not_reg  <= not_c;
            nos_reg  <= nos_c;
        end
    end

    always_comb begin
        op_update = (func_reg <= FN_RECV_ZERO);
        op_sample = (func_reg == FN_SAMPLE) || (func_reg == FN_SAMPLE_ZERO);
        op_send   = (func_reg == FN_SEND) || (func_reg == FN_SEND_ZERO);
        wr_en     = op_update && (hit_reg || free_reg);

        // zero mode compares length minus share, rearranged as two sums
        lhs_sum = {1'b0, rlen_reg} + {1'b0, not_reg};
        rhs_sum = {1'b0, npt_reg} + {1'b0, rsh_reg};
        if (func_reg == FN_RECV_ZERO) begin
            take_c = lhs_sum > rhs_sum;
        end else begin
            take_c = (func_reg == FN_RECV) && (rlen_reg > npt_reg);
        end
        wr_pt = take_c ? rlen_reg : npt_reg;
        wr_ot = take_c ? rsh_reg  : not_reg;

        zero_diff = (npt_reg >= not_reg) ? npt_reg - not_reg : '0;

        emit   = 1'b0;
        kind_c = KIND_PATH;
        len_c  = npt_reg;
        sh_c   = not_reg;
        if (op_update && !hit_reg && !free_reg) begin
            emit   = 1'b1;
            kind_c = KIND_FULL;
            len_c  = '0;
            sh_c   = '0;
        end else if (op_send) begin
            emit   = 1'b1;
            kind_c = (func_reg == FN_SEND_ZERO) ? KIND_PATH_ZERO : KIND_PATH;
        end else if (op_sample && hit_reg) begin
            emit   = 1'b1;
            kind_c = KIND_SAMPLE;
            if (func_reg == FN_SAMPLE_ZERO) begin
                len_c = zero_diff;
                sh_c  = zero_diff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && wr_en) begin
            run_mem[slot_reg] <= nrun_reg;
            pt_mem[slot_reg]  <= wr_pt;
            ps_mem[slot_reg]  <= nps_reg;
            ot_mem[slot_reg]  <= wr_ot;
            os_mem[slot_reg]  <= nos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.finish && wr_en && !hit_reg) begin
            valid_reg[slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && wr_en && !hit_reg) begin
            key_reg[slot_reg] <= id_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish && emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && emit) begin
            out_kind_reg <= kind_c;
            out_id_reg   <= id_reg;
            out_len_reg  <= len_c;
            out_sh_reg   <= sh_c;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_kind        = out_kind_reg;
    assign out_id          = out_id_reg;
    assign out_length      = out_len_reg;
    assign out_share       = out_sh_reg;

endmodule

`default_nettype wire

// ===== tb/critical_path_accumulator_table_unit_tb.sv =====
// self-checking testbench for the critical path accumulator table unit
`timescale 1ns / 100ps

module critical_path_accumulator_table_unit_tb;
    import cpat_pkg::*;

    // block configuration, matches the defaults of the top level
    localparam int ID_W  = 16;
    localparam int T_W   = 48;
    localparam int SLOTS = 16;
    localparam int S_W   = ((ID_W + 3 * T_W + 7) / 8) * 8;
    localparam int M_W   = ((ID_W + 2 * T_W + 7) / 8) * 8;

    localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

    // operation codes the block has to ignore
    localparam logic [3:0] FN_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] FN_UNKNOWN_HI = 4'd15;

    localparam int ID_POOL       = 18;   // a bit more ids than slots, so the table fills up
    localparam int RANDOM_ITEMS  = 560;
    localparam int BURST_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 24;   // idle time after the drain, before the verdict
    localparam int STALL_LIMIT   = 2000; // cycles with no transfer on either side

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] id;
        logic [T_W-1:0]  length;
        logic [T_W-1:0]  share;
    } record_t;

    logic            aclk     = 1'b0;
    logic            aresetn  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [S_W-1:0]  s_tdata  = '0;
    logic [3:0]      s_tuser  = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [M_W-1:0]  m_tdata;
    logic [1:0]      m_tuser;

    // predicted table contents, one entry per slot
    logic            slot_used    [SLOTS];
    logic [ID_W-1:0] slot_key     [SLOTS];
    logic            slot_running [SLOTS];
    logic [T_W-1:0]  path_acc     [SLOTS];
    logic [T_W-1:0]  path_mark    [SLOTS];
    logic [T_W-1:0]  own_acc      [SLOTS];
    logic [T_W-1:0]  own_mark     [SLOTS];

    record_t         expected_records [$];
    logic [ID_W-1:0] id_pool [ID_POOL];
    logic [T_W-1:0]  tick = 48'd5000;    // free running cpu time for random traffic
    bit              idling = 1'b1;      // random gaps and stalls on both sides
    int              stall_left = 0;
    int              quiet_cycles = 0;
    int              mismatches = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    critical_path_accumulator_table_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // id, now, remote_length, remote_share
        .s_tuser  (s_tuser),    // func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // out_id, length, share
        .m_tuser  (m_tuser)     // kind
    );

    // ------------------------------------------------------------------
    // table predictor
    // ------------------------------------------------------------------

    // sum clipped to the all-ones time value
    function automatic logic [T_W-1:0] add_sat(input logic [T_W-1:0] a, input logic [T_W-1:0] b);
        logic [T_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[T_W] ? T_MAX : sum[T_W-1:0];
    endfunction

    // a - b, or zero when time went backwards
    function automatic logic [T_W-1:0] elapsed(input logic [T_W-1:0] a, input logic [T_W-1:0] b);
        return (a >= b) ? a - b : '0;
    endfunction

    function automatic void advance_path(input int slot, input logic [T_W-1:0] now);
        path_acc[slot]  = add_sat(path_acc[slot], elapsed(now, path_mark[slot]));
        path_mark[slot] = now;
    endfunction

    function automatic void advance_own(input int slot, input logic [T_W-1:0] now);
        own_acc[slot]  = add_sat(own_acc[slot], elapsed(now, own_mark[slot]));
        own_mark[slot] = now;
    endfunction

    function automatic void expect_record(input logic [1:0] kind, input logic [ID_W-1:0] id,
                                          input logic [T_W-1:0] length,
                                          input logic [T_W-1:0] share);
        record_t rec;
        rec.kind   = kind;
        rec.id     = id;
        rec.length = length;
        rec.share  = share;
        expected_records.push_back(rec);
    endfunction

    // applies one accepted operation to the predicted table, queues its record if any
    function automatic void predict_table_op(input logic [3:0] fn, input logic [ID_W-1:0] id,
                                             input logic [T_W-1:0] now,
                                             input logic [T_W-1:0] rlen,
                                             input logic [T_W-1:0] rsh);
        int             i;
        int             hit;
        int             free_slot;
        logic [T_W-1:0] len;
        logic [T_W-1:0] sh;
        logic           take;
        hit = -1;
        free_slot = -1;
        if (fn > FN_SAMPLE_ZERO)
            return;
        for (i = 0; i < SLOTS; i++) begin
            if (hit < 0 && slot_used[i] && slot_key[i] == id)
                hit = i;
            if (!slot_used[i] && free_slot < 0)
                free_slot = i;
        end

        // samples only look, a missing id gives nothing even on a full table
        if (fn == FN_SAMPLE || fn == FN_SAMPLE_ZERO) begin
            if (hit < 0)
                return;
            len = add_sat(path_acc[hit], elapsed(now, path_mark[hit]));
            sh  = own_acc[hit];
            if (slot_running[hit])
                sh = add_sat(sh, elapsed(now, own_mark[hit]));
            if (fn == FN_SAMPLE_ZERO) begin
                len = elapsed(len, sh);   // length minus share, floored at zero
                sh  = len;
            end
            expect_record(KIND_SAMPLE, id, len, sh);
            return;
        end

        if (hit < 0) begin
            if (free_slot < 0) begin
                expect_record(KIND_FULL, id, '0, '0);
                return;
            end
            hit = free_slot;
            slot_used[hit]    = 1'b1;
            slot_key[hit]     = id;
            slot_running[hit] = 1'b0;
            path_acc[hit]     = '0;
            path_mark[hit]    = now;
            own_acc[hit]      = '0;
            own_mark[hit]     = now;
        end

        case (fn)
            FN_SET_ACTIVE: begin
                slot_running[hit] = 1'b1;
            end
            FN_START: begin
                slot_running[hit] = 1'b1;
                own_mark[hit] = now;
                advance_path(hit, now);
            end
            FN_STOP: begin
                slot_running[hit] = 1'b0;
                advance_own(hit, now);
                advance_path(hit, now);
            end
            FN_SEND, FN_SEND_ZERO: begin
                advance_path(hit, now);
                if (slot_running[hit])
                    advance_own(hit, now);
                expect_record((fn == FN_SEND_ZERO) ? KIND_PATH_ZERO : KIND_PATH, id,
                              path_acc[hit], own_acc[hit]);
            end
            default: begin
                advance_path(hit, now);
                if (slot_running[hit])
                    advance_own(hit, now);
                // zero mode compares length minus share on both sides, kept exact
                if (fn == FN_RECV_ZERO)
                    take = ({1'b0, rlen} + own_acc[hit]) > ({1'b0, path_acc[hit]} + rsh);
                else
                    take = rlen > path_acc[hit];
                if (take) begin
                    path_acc[hit] = rlen;
                    own_acc[hit]  = rsh;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // one transfer on the input channel, optionally after a random gap;
    // tvalid stays high afterwards so back-to-back items need no extra edge
    task automatic send_op(input logic [3:0] fn, input logic [ID_W-1:0] id,
                           input logic [T_W-1:0] now, input logic [T_W-1:0] rlen,
                           input logic [T_W-1:0] rsh);
        int gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {rsh, rlen, now, id};
        do @(posedge aclk); while (!s_tready);
        predict_table_op(fn, id, now, rlen, rsh);
    endtask

    // drop tvalid and hold off until every queued record has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_records.size() != 0);
    endtask

    // mostly known ids and a forward running clock, with some noise mixed in
    task automatic send_random_op();
        logic [3:0]      fn;
        logic [ID_W-1:0] id;
        logic [T_W-1:0]  now;
        logic [T_W-1:0]  rlen;
        logic [T_W-1:0]  rsh;
        int              roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            fn = 4'($urandom_range(FN_UNKNOWN_LO, FN_UNKNOWN_HI));
        else
            fn = 4'($urandom_range(FN_SET_ACTIVE, FN_SAMPLE_ZERO));

        roll = $urandom_range(0, 99);
        if (roll < 3)
            id = ID_W'($urandom);
        else
            id = id_pool[$urandom_range(0, ID_POOL - 1)];

        tick = tick + $urandom_range(0, 4000);
        roll = $urandom_range(0, 99);
        if (roll < 2)
            now = T_W'({$urandom, $urandom});
        else if (roll < 8)
            now = tick - $urandom_range(0, 3000);   // clock steps back
        else
            now = tick;

        // remote lengths around the local totals, so recv takes about half the time
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            rlen = T_W'({$urandom, $urandom});
            rsh  = T_W'({$urandom, $urandom});
        end else begin
            rlen = T_W'($urandom_range(0, tick[31:0]));
            rsh  = T_W'($urandom_range(0, rlen[31:0]));
        end
        send_op(fn, id, now, rlen, rsh);
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------

    // receiver stalls in random bursts while idling is on
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // each result transfer against the oldest queued record
    always @(posedge aclk) begin : result_check
        record_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_records.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected record: kind %0d id %h length %h share %h",
                             m_tuser, m_tdata[ID_W-1:0], m_tdata[ID_W+T_W-1:ID_W],
                             m_tdata[ID_W+2*T_W-1:ID_W+T_W]);
                mismatches++;
            end else begin
                want = expected_records.pop_front();
                if (m_tuser !== want.kind || m_tdata[ID_W-1:0] !== want.id
                        || m_tdata[ID_W+T_W-1:ID_W] !== want.length
                        || m_tdata[ID_W+2*T_W-1:ID_W+T_W] !== want.share) begin
                    if (mismatches < 10) begin
                        $display("record mismatch: expected kind %0d id %h length %h share %h",
                                 want.kind, want.id, want.length, want.share);
                        $display("                 actual   kind %0d id %h length %h share %h",
                                 m_tuser, m_tdata[ID_W-1:0], m_tdata[ID_W+T_W-1:ID_W],
                                 m_tdata[ID_W+2*T_W-1:ID_W+T_W]);
                    end
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long without any transfer means the block hung
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every operation, clock running backwards, saturation and the wide recv_zero compare
    task automatic test_directed_ops();
        send_op(FN_SET_ACTIVE,  16'h0000, 48'd0,   '0, '0);
        send_op(FN_SEND,        16'h0000, 48'd100, '0, '0);
        send_op(FN_STOP,        16'h0000, 48'd50,  '0, '0);   // time went backwards
        send_op(FN_SEND_ZERO,   16'h0000, 48'd150, '0, '0);
        send_op(FN_SAMPLE,      16'h0000, 48'd10,  '0, '0);
        send_op(FN_SAMPLE_ZERO, 16'h0000, 48'd300, '0, '0);
        send_op(FN_RECV,        16'h0000, 48'd150, 48'd1000, 48'd7);
        // sums past the time width on both sides, not taken then taken
        send_op(FN_RECV_ZERO,   16'h0000, 48'd160, T_MAX, T_MAX);
        send_op(FN_RECV_ZERO,   16'h0000, 48'd170, T_MAX, '0);
        send_op(FN_SEND,        16'h0000, T_MAX,   '0, '0);   // path total saturates
        send_op(FN_SAMPLE,      16'h0000, T_MAX,   '0, '0);
        send_op(FN_START,       16'hFFFF, T_MAX,   '0, '0);
        send_op(FN_RECV,        16'hFFFF, T_MAX,   '0, T_MAX);
        send_op(FN_SAMPLE_ZERO, 16'hFFFF, 48'd0,   '0, '0);
        send_op(FN_STOP,        16'hFFFF, 48'd5,   '0, '0);
        send_op(FN_SEND_ZERO,   16'hFFFF, 48'd9,   '0, '0);
        // ignored codes
        send_op(FN_UNKNOWN_LO,  16'h0000, 48'd400, T_MAX, T_MAX);
        send_op(FN_UNKNOWN_HI,  16'hFFFF, 48'd400, T_MAX, T_MAX);
        // sample of an id that is not there gives nothing
        send_op(FN_SAMPLE,      16'h1234, 48'd450, '0, '0);
        // allocation by send and by recv
        send_op(FN_SEND,        16'h1234, 48'd500, '0, '0);
        send_op(FN_RECV,        16'h5678, 48'd600, 48'd1000, 48'd1);
    endtask

    // random mix over a small id pool; the table fills and overflows along the way
    task automatic test_random_traffic();
        int k;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (k = 2; k < ID_POOL; k++)
            id_pool[k] = ID_W'($urandom);
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            idling = ((k / 60) % 3) != 2;   // every third stretch runs without gaps
            if (k == RANDOM_ITEMS / 2)
                wait_drained();
            send_random_op();
        end
    endtask

    // table full: every non-sample op on a new id errors, sample of a missing id stays quiet
    task automatic test_table_full();
        int k;
        idling = 1'b1;
        for (k = 0; k < SLOTS; k++)
            send_op(FN_SET_ACTIVE, 16'h0100 + k[ID_W-1:0], tick, '0, '0);
        send_op(FN_SEND,        16'hABCD, tick, '0, '0);
        send_op(FN_STOP,        16'hABCE, tick, '0, '0);
        send_op(FN_RECV_ZERO,   16'hABCF, tick, T_MAX, '0);
        send_op(FN_SAMPLE,      16'hABCD, tick, '0, '0);
        send_op(FN_SAMPLE_ZERO, 16'h0000, tick, '0, '0);
    endtask

    // closing stretch at full rate, no gaps and no stalls
    task automatic test_back_to_back();
        int k;
        idling = 1'b0;
        for (k = 0; k < BURST_ITEMS; k++)
            send_random_op();
    endtask

    initial begin
        int i;
        for (i = 0; i < SLOTS; i++)
            slot_used[i] = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_ops();
        test_random_traffic();
        test_table_full();
        test_back_to_back();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_records.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
